[rtl/fseg_pkg.sv]
`timescale 1ns / 1ps

package fseg_pkg;

    localparam int COUNT_W    = 32;
    localparam int LEN_W      = 24;
    localparam int LEVEL_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = LEVEL_W + LEN_W;
    // quotient is below 2^LEVEL_W since elapsed stays below the segment length
    localparam int DIV_STEPS  = LEVEL_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int TIME_LSBS  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_SAMPLES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_ONE_SAMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_TWO_SAMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_SAMPLES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_PEAK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_ONE_LEVEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_LEVELS     = 3'd7;

    typedef enum logic [2:0] {
        SEG_IDLE       = 3'd0,
        SEG_ATTACK     = 3'd1,
        SEG_DECAY1     = 3'd2,
        SEG_DECAY2     = 3'd3,
        SEG_ON_STEADY  = 3'd4,
        SEG_RELEASE    = 3'd5,
        SEG_OFF_STEADY = 3'd6
    } seg_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_EVENT,
        SEQ_ELAPSED,
        SEQ_CLIP,
        SEQ_START,
        SEQ_DIVIDE,
        SEQ_DONE
    } seq_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic [LEN_W-1:0]      attack_samples;
        logic [LEN_W-1:0]      decay_one_samples;
        logic [LEN_W-1:0]      decay_two_samples;
        logic [LEN_W-1:0]      release_samples;
        logic [LEVEL_W-1:0]    attack_peak_level;
        logic [LEVEL_W-1:0]    decay_one_level;
        logic [LEVEL_W-1:0]    sustain_level;
        logic [CFG_DATA_W-1:0] rest_levels;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] mag;
        logic [LEN_W-1:0]   elapsed;
        logic [LEN_W-1:0]   length;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] level;
        logic [2:0]         segment;
    } res_t;

endpackage

[rtl/four_segment_envelope_generator.sv]
`timescale 1ns / 1ps

// channel   handshake                 payload
// input     in_valid / in_ready       mode, key_on, sample_count
// output    out_valid / out_ready     level, segment
// config    cfg_we (no wait)          cfg_index, cfg_data
//
// an item is finished before the next in_ready; a zero-length segment skips the
// divide, any other runs the 16-step shift-subtract divider on the item
// reset clears the envelope state to idle and loads the register defaults
// the next item may be taken while a result waits in the output register;
// a finished result holds the sequencer until the output register frees up

module four_segment_envelope_generator
    import fseg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic                  key_on,
    input  logic [COUNT_W-1:0]    sample_count,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LEVEL_W-1:0]    level,
    output logic [2:0]            segment,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;
    res_t     res;
    logic     res_ready;

    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [2:0]         segment_reg, segment_next;

    fseg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fseg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .key_on       (key_on),
        .sample_count (sample_count),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .res          (res),
        .res_ready    (res_ready)
    );

    fseg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        level_next     = level_reg;
        segment_next   = segment_reg;
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
            level_next     = res.level;
            segment_next   = res.segment;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg   <= level_next;
        segment_reg <= segment_next;
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign segment   = segment_reg;

`ifndef SYNTHESIS
    // one item at a time: a transfer closes the input side
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // a pending result and the divider finishing both belong to a busy block
    a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !in_ready)
        else $error("result pending while input is open");

    a_div_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> !in_ready && !div_req.start)
        else $error("divider finished outside an item");

    // a divide never completes on the cycle right after it was started
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |=> !div_rsp.done)
        else $error("divider answered too early");
`endif

endmodule

[rtl/fseg_cfg.sv]
`timescale 1ns / 1ps

module fseg_cfg
    import fseg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ATTACK_SAMPLES:  cfg_next.attack_samples    = cfg_data[LEN_W-1:0];
                CFG_DECAY_ONE_SAMP:  cfg_next.decay_one_samples = cfg_data[LEN_W-1:0];
                CFG_DECAY_TWO_SAMP:  cfg_next.decay_two_samples = cfg_data[LEN_W-1:0];
                CFG_RELEASE_SAMPLES: cfg_next.release_samples   = cfg_data[LEN_W-1:0];
                CFG_ATTACK_PEAK:     cfg_next.attack_peak_level = cfg_data[LEVEL_W-1:0];
                CFG_DECAY_ONE_LEVEL: cfg_next.decay_one_level   = cfg_data[LEVEL_W-1:0];
                CFG_SUSTAIN_LEVEL:   cfg_next.sustain_level     = cfg_data[LEVEL_W-1:0];
                CFG_REST_LEVELS:     cfg_next.rest_levels       = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // all registers clear except the attack peak, which resets to full scale
            cfg_reg <= {{(4*LEN_W){1'b0}}, {LEVEL_W{1'b1}},
                        {(2*LEVEL_W + CFG_DATA_W){1'b0}}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/fseg_div.sv]
`timescale 1ns / 1ps

module fseg_div
    import fseg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    div_state_t          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [LEVEL_W-1:0]  quo_reg, quo_next;

    logic [PROD_W-1:0]   prod;
    logic [LEN_W:0]      shifted;
    logic [LEN_W:0]      trial;
    logic                fits;

    // operands are held stable by the sequencer while the divide runs
    assign prod    = PROD_W'(req.mag) * PROD_W'(req.elapsed);
    assign shifted = {rem_reg, quo_reg[LEVEL_W-1]};
    assign trial   = shifted - {1'b0, req.length};
    assign fits    = (shifted >= {1'b0, req.length});

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        rsp.done     = 1'b0;
        rsp.quotient = quo_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (req.start)
                begin
                    state_next = DIV_MUL;
                end
            end
            DIV_MUL:
            begin
                // upper part is already below the divisor
                rem_next   = prod[PROD_W-1:LEVEL_W];
                quo_next   = prod[LEVEL_W-1:0];
                step_next  = '0;
                state_next = DIV_RUN;
            end
            DIV_RUN:
            begin
                rem_next  = fits ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
                quo_next  = {quo_reg[LEVEL_W-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = DIV_IDLE;
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

[rtl/fseg_ctrl.sv]
`timescale 1ns / 1ps

module fseg_ctrl
    import fseg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic               key_on,
    input  logic [COUNT_W-1:0] sample_count,
    output div_req_t           div_req,
    input  div_rsp_t           div_rsp,
    output res_t               res,
    input  logic               res_ready
);

    seq_state_t          seq_reg, seq_next;
    seg_t                seg_reg, seg_next;
    logic [COUNT_W-1:0]  cur_count_reg, cur_count_next;
    logic [COUNT_W-1:0]  start_count_reg, start_count_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEVEL_W-1:0]  start_level_reg, start_level_next;
    logic [LEVEL_W-1:0]  end_level_reg, end_level_next;
    logic [LEVEL_W-1:0]  level_now_reg, level_now_next;

    logic                mode_reg, mode_next;
    logic                key_reg, key_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                below_reg, below_next;
    logic [COUNT_W-1:0]  since_reg, since_next;
    logic [LEN_W-1:0]    elapsed_reg, elapsed_next;
    logic                neg_reg, neg_next;
    logic [LEVEL_W-1:0]  mag_reg, mag_next;

    logic [COUNT_W:0]    end_count;
    logic                end_reached;
    logic [COUNT_W:0]    since_full;
    logic [LEVEL_W:0]    level_diff;
    logic [LEVEL_W:0]    level_diff_neg;
    logic [COUNT_W-1:0]  clamp_base;
    logic [LEN_W-1:0]    clipped;
    logic [LEVEL_W-1:0]  part;

    assign end_count      = {1'b0, start_count_reg} + (COUNT_W + 1)'(len_reg);
    assign end_reached    = ({1'b0, count_reg} >= end_count);
    assign since_full     = {1'b0, cur_count_reg} - {1'b0, start_count_reg};
    assign level_diff     = {1'b0, end_level_reg} - {1'b0, start_level_reg};
    assign level_diff_neg = ~level_diff + 1'b1;
    assign clamp_base     = below_reg ? '0 : since_reg;
    assign clipped        = (clamp_base >= COUNT_W'(len_reg)) ? (len_reg - 1'b1)
                                                              : clamp_base[LEN_W-1:0];
    assign part           = neg_reg ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;

    always_comb
    begin
        seq_next         = seq_reg;
        seg_next         = seg_reg;
        cur_count_next   = cur_count_reg;
        start_count_next = start_count_reg;
        len_next         = len_reg;
        start_level_next = start_level_reg;
        end_level_next   = end_level_reg;
        level_now_next   = level_now_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        count_next       = count_reg;
        below_next       = below_reg;
        since_next       = since_reg;
        elapsed_next     = elapsed_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        in_ready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.mag      = mag_reg;
        div_req.elapsed  = elapsed_reg;
        div_req.length   = len_reg;
        res.valid        = 1'b0;
        res.level        = level_now_reg;
        res.segment      = seg_reg;

        case (seq_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mode_next  = mode;
                    key_next   = key_on;
                    count_next = sample_count;
                    seq_next   = SEQ_EVENT;
                end
            end
            SEQ_EVENT:
            begin
                if (!mode_reg)
                begin
                    case (seg_reg)
                        SEG_IDLE, SEG_OFF_STEADY:
                        begin
                            if (key_reg)
                            begin
                                seg_next         = SEG_ATTACK;
                                start_count_next = '0;
                                len_next         = cfg.attack_samples;
                                start_level_next = cfg.rest_levels[LEVEL_W-1:0];
                                end_level_next   = cfg.attack_peak_level;
                            end
                        end
                        SEG_ATTACK, SEG_DECAY1, SEG_DECAY2, SEG_ON_STEADY:
                        begin
                            if (!key_reg)
                            begin
                                seg_next         = SEG_RELEASE;
                                start_count_next = cur_count_reg;
                                len_next         = cfg.release_samples;
                                start_level_next = level_now_reg;
                                end_level_next   = cfg.rest_levels[2*LEVEL_W-1:LEVEL_W];
                            end
                        end
                        default:
                        begin
                            seg_next = seg_reg;
                        end
                    endcase
                end
                else
                begin
                    cur_count_next = count_reg;
                    if (end_reached)
                    begin
                        case (seg_reg)
                            SEG_ATTACK:
                            begin
                                seg_next         = SEG_DECAY1;
                                start_count_next = count_reg;
                                len_next         = cfg.decay_one_samples;
                                start_level_next = end_level_reg;
                                end_level_next   = cfg.decay_one_level;
                            end
                            SEG_DECAY1:
                            begin
                                seg_next         = SEG_DECAY2;
                                start_count_next = count_reg;
                                len_next         = cfg.decay_two_samples;
                                start_level_next = end_level_reg;
                                end_level_next   = cfg.sustain_level;
                            end
                            SEG_DECAY2:
                            begin
                                seg_next         = SEG_ON_STEADY;
                                start_count_next = count_reg;
                                len_next         = '0;
                                level_now_next   = end_level_reg;
                            end
                            SEG_RELEASE:
                            begin
                                seg_next         = SEG_OFF_STEADY;
                                start_count_next = count_reg;
                                len_next         = '0;
                                level_now_next   = end_level_reg;
                            end
                            default:
                            begin
                                seg_next = seg_reg;
                            end
                        endcase
                    end
                end
                seq_next = SEQ_ELAPSED;
            end
            SEQ_ELAPSED:
            begin
                below_next = since_full[COUNT_W];
                since_next = since_full[COUNT_W-1:0];
                neg_next   = level_diff[LEVEL_W];
                mag_next   = level_diff[LEVEL_W] ? level_diff_neg[LEVEL_W-1:0]
                                                 : level_diff[LEVEL_W-1:0];
                // zero-length segment keeps the held level
                if (len_reg == '0)
                begin
                    seq_next = SEQ_DONE;
                end
                else
                begin
                    seq_next = SEQ_CLIP;
                end
            end
            SEQ_CLIP:
            begin
                elapsed_next = {clipped[LEN_W-1:TIME_LSBS], TIME_LSBS'(0)};
                seq_next     = SEQ_START;
            end
            SEQ_START:
            begin
                div_req.start = 1'b1;
                seq_next      = SEQ_DIVIDE;
            end
            SEQ_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    level_now_next = start_level_reg + part;
                    seq_next       = SEQ_DONE;
                end
            end
            SEQ_DONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    seq_next = SEQ_IDLE;
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg         <= SEQ_IDLE;
            seg_reg         <= SEG_IDLE;
            cur_count_reg   <= '0;
            start_count_reg <= '0;
            len_reg         <= '0;
            start_level_reg <= '0;
            end_level_reg   <= '0;
            level_now_reg   <= '0;
        end
        else
        begin
            seq_reg         <= seq_next;
            seg_reg         <= seg_next;
            cur_count_reg   <= cur_count_next;
            start_count_reg <= start_count_next;
            len_reg         <= len_next;
            start_level_reg <= start_level_next;
            end_level_reg   <= end_level_next;
            level_now_reg   <= level_now_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        count_reg   <= count_next;
        below_reg   <= below_next;
        since_reg   <= since_next;
        elapsed_reg <= elapsed_next;
        neg_reg     <= neg_next;
        mag_reg     <= mag_next;
    end

endmodule
